FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define CHK_HOLDS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define CHK_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pl0lx_pkg.sv
// ---------------------------------------------------------------------------
// pl0lx_pkg
// Types, token codes, keyword table and character classes for the PL/0 lexer.
// ---------------------------------------------------------------------------
package pl0lx_pkg;

    // Default sizes
    localparam int IDENT_MAX_DEF      = 11;
    localparam int NUM_DIGITS_MAX_DEF = 5;
    localparam int LINE_BITS_DEF      = 16;

    // Results produced by one item at most
    localparam int MAX_RESULTS = 12;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Token codes
    typedef enum logic [5:0] {
        TOK_NONE    = 6'd0,
        TOK_NULL    = 6'd1,
        TOK_IDENT   = 6'd2,
        TOK_NUMBER  = 6'd3,
        TOK_PLUS    = 6'd4,
        TOK_MINUS   = 6'd5,
        TOK_TIMES   = 6'd6,
        TOK_SLASH   = 6'd7,
        TOK_ODD     = 6'd8,
        TOK_EQ      = 6'd9,
        TOK_NE      = 6'd10,
        TOK_LT      = 6'd11,
        TOK_LE      = 6'd12,
        TOK_GT      = 6'd13,
        TOK_GE      = 6'd14,
        TOK_LPAREN  = 6'd15,
        TOK_RPAREN  = 6'd16,
        TOK_COMMA   = 6'd17,
        TOK_SEMI    = 6'd18,
        TOK_PERIOD  = 6'd19,
        TOK_BECOMES = 6'd20,
        TOK_BEGIN   = 6'd21,
        TOK_END     = 6'd22,
        TOK_IF      = 6'd23,
        TOK_THEN    = 6'd24,
        TOK_WHILE   = 6'd25,
        TOK_DO      = 6'd26,
        TOK_CALL    = 6'd27,
        TOK_CONST   = 6'd28,
        TOK_VAR     = 6'd29,
        TOK_PROC    = 6'd30,
        TOK_WRITE   = 6'd31,
        TOK_READ    = 6'd32,
        TOK_ELSE    = 6'd33
    } t_tok;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_NAME_LONG  = 3'd1,
        ERR_NUM_LONG   = 3'd2,
        ERR_LETTER_NUM = 3'd3,
        ERR_BAD_SYMBOL = 3'd4
    } t_err;

    // Scanner states
    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_NUM,
        M_LT,
        M_GT,
        M_COLON,
        M_SLASH,
        M_COMMENT,
        M_CSTAR
    } t_mode;

    // Channel payloads
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [5:0]  token_id;
        logic [7:0]  ident_char;
        logic [3:0]  char_pos;
        logic [16:0] number_value;
        logic [2:0]  error_code;
        logic [15:0] error_line;
        logic        done_res;
        logic        last;
    } t_out;

    // Command passed from scanner to emitter
    typedef struct packed {
        t_tok        tok;
        logic        is_ident;   // expand buffered name into char results
        logic [16:0] num;
        t_err        err;
        logic [15:0] eline;
        logic        done;
        logic        last;       // closes the results of one item
    } t_cmd;

    // Keyword table, words right-justified
    localparam int KW_COUNT   = 15;
    localparam int KW_LEN_MAX = 9;

    localparam logic [8*KW_LEN_MAX-1:0] KW_WORD [KW_COUNT] = '{
        "odd", "begin", "end", "if", "then", "while", "do", "call",
        "const", "var", "procedure", "write", "read", "else", "null"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd2, 4'd4,
        4'd5, 4'd3, 4'd9, 4'd5, 4'd4, 4'd4, 4'd4
    };

    localparam t_tok KW_TOK [KW_COUNT] = '{
        TOK_ODD, TOK_BEGIN, TOK_END, TOK_IF, TOK_THEN, TOK_WHILE, TOK_DO,
        TOK_CALL, TOK_CONST, TOK_VAR, TOK_PROC, TOK_WRITE, TOK_READ,
        TOK_ELSE, TOK_NULL
    };

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "(" ||
               c == ")" || c == "=" || c == "," || c == "." || c == "<" ||
               c == ">" || c == ";" || c == ":";
    endfunction

    // Tokens complete in one character
    function automatic t_tok single_tok(input logic [7:0] c);
        t_tok t;
        case (c)
            "+":     t = TOK_PLUS;
            "-":     t = TOK_MINUS;
            "*":     t = TOK_TIMES;
            "=":     t = TOK_EQ;
            "(":     t = TOK_LPAREN;
            ")":     t = TOK_RPAREN;
            ",":     t = TOK_COMMA;
            ";":     t = TOK_SEMI;
            ".":     t = TOK_PERIOD;
            default: t = TOK_NONE;
        endcase
        return t;
    endfunction

    // A fresh character yields a result at once (token or bad symbol)
    function automatic logic idle_emits(input logic [7:0] c);
        return !(c == CH_SPACE || c == CH_NL || is_alpha(c) || is_digit(c) ||
                 c == "<" || c == ">" || c == ":" || c == "/");
    endfunction

endpackage

FILE: rtl/core/pl0lx_front.sv
// ---------------------------------------------------------------------------
// pl0lx_front
// Scanner: takes one source byte per cycle while the queue has room, tracks
// the lexical state and issues token commands to the queue. A byte that ends
// a pending token is held: first the pending token goes out, then the byte
// is scanned fresh.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pl0lx_front import pl0lx_pkg::*; #(
    parameter int IDENT_MAX      = IDENT_MAX_DEF,
    parameter int NUM_DIGITS_MAX = NUM_DIGITS_MAX_DEF,
    parameter int LINE_BITS      = LINE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  t_in                           i_in,
    output logic                          o_push,
    input  logic                          i_q_ready,
    output t_cmd                          o_cmd,
    output logic [IDENT_MAX-1:0][7:0]     o_ident,
    output logic [$clog2(IDENT_MAX+1)-1:0] o_len
);

    localparam int LEN_W  = $clog2(IDENT_MAX + 1);
    localparam int POS_W  = (IDENT_MAX > 1) ? $clog2(IDENT_MAX) : 1;
    localparam int ACC_W  = $clog2(10 ** NUM_DIGITS_MAX);
    localparam int DCNT_W = $clog2(NUM_DIGITS_MAX + 1);

    t_mode                       r_mode, n_mode;
    logic [IDENT_MAX-1:0][7:0]   r_buf, n_buf;
    logic [LEN_W-1:0]            r_len, n_len;
    logic [ACC_W-1:0]            r_acc, n_acc;
    logic [DCNT_W-1:0]           r_dcnt, n_dcnt;
    logic [LINE_BITS-1:0]        r_line, n_line;
    t_err                        r_err, n_err;

    logic [7:0] c;
    logic       eot, c_alpha, c_digit, c_alnum, c_special, c_emit;
    t_tok       c_tok;
    logic       pending, name_full, num_full;

    t_err  raise;
    logic  flush, done_now, consume, last_v, push, adv;
    t_tok  tok_now;
    t_cmd  cmd;

    logic [KW_LEN_MAX-1:0][7:0] pad;
    logic                       kw_hit;
    t_tok                       kw_tok;

    // Character classes
    assign c         = i_in.ch;
    assign eot       = i_in.end_of_text;
    assign c_alpha   = is_alpha(c);
    assign c_digit   = is_digit(c);
    assign c_alnum   = c_alpha || c_digit;
    assign c_special = is_special(c);
    assign c_tok     = single_tok(c);
    assign c_emit    = idle_emits(c);
    assign pending   = (r_mode == M_IDENT) || (r_mode == M_NUM) || (r_mode == M_LT) ||
                       (r_mode == M_GT) || (r_mode == M_COLON) || (r_mode == M_SLASH);
    assign name_full = (r_len == LEN_W'(IDENT_MAX));
    assign num_full  = (r_dcnt == DCNT_W'(NUM_DIGITS_MAX));

    // Name buffer padded to the longest keyword
    for (genvar j = 0; j < KW_LEN_MAX; j++) begin : g_pad
        if (j < IDENT_MAX) begin : g_hold
            assign pad[j] = r_buf[j];
        end else begin : g_zero
            assign pad[j] = '0;
        end
    end

    // Keyword match on the buffered name
    always_comb begin
        logic hit;
        kw_hit = 1'b0;
        kw_tok = TOK_NONE;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (int'(r_len) == int'(KW_LEN[k]));
            for (int j = 0; j < KW_LEN_MAX; j++) begin
                if (j < int'(KW_LEN[k])) begin
                    if (pad[j] != KW_WORD[k][8*(int'(KW_LEN[k])-1-j) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit && !kw_hit) begin
                kw_hit = 1'b1;
                kw_tok = KW_TOK[k];
            end
        end
    end

    // Output decode: what this byte produces and whether it is taken
    always_comb begin
        raise    = ERR_NONE;
        flush    = 1'b0;
        tok_now  = TOK_NONE;
        done_now = 1'b0;
        consume  = 1'b1;
        last_v   = 1'b1;
        if (eot) begin
            if (r_err == ERR_NONE && pending) begin
                consume = 1'b0;
                last_v  = 1'b0;
                if (r_mode == M_COLON) begin
                    raise = ERR_BAD_SYMBOL;
                end else begin
                    flush = 1'b1;
                end
            end else begin
                done_now = 1'b1;
            end
        end else if (r_err == ERR_NONE) begin
            case (r_mode)
                M_IDENT: begin
                    if (c_alnum) begin
                        if (name_full) raise = ERR_NAME_LONG;
                    end else begin
                        flush   = 1'b1;
                        consume = 1'b0;
                        last_v  = !c_emit;
                    end
                end
                M_NUM: begin
                    if (c_digit) begin
                        if (num_full) raise = ERR_NUM_LONG;
                    end else if (c_alpha) begin
                        raise = ERR_LETTER_NUM;
                    end else begin
                        flush   = 1'b1;
                        consume = 1'b0;
                        last_v  = !c_emit;
                    end
                end
                M_LT: begin
                    if (c == ">") begin
                        tok_now = TOK_NE;
                    end else if (c == "=") begin
                        tok_now = TOK_LE;
                    end else if (c_special) begin
                        raise = ERR_BAD_SYMBOL;
                    end else begin
                        flush   = 1'b1;
                        consume = 1'b0;
                        last_v  = !c_emit;
                    end
                end
                M_GT: begin
                    if (c == "=") begin
                        tok_now = TOK_GE;
                    end else if (c_special) begin
                        raise = ERR_BAD_SYMBOL;
                    end else begin
                        flush   = 1'b1;
                        consume = 1'b0;
                        last_v  = !c_emit;
                    end
                end
                M_COLON: begin
                    if (c == "=") tok_now = TOK_BECOMES;
                    else          raise   = ERR_BAD_SYMBOL;
                end
                M_SLASH: begin
                    if (c != "*") begin
                        flush   = 1'b1;
                        consume = 1'b0;
                        last_v  = !c_emit;
                    end
                end
                M_COMMENT, M_CSTAR: begin
                end
                default: begin
                    if (c_emit) begin
                        if (c_tok != TOK_NONE) tok_now = c_tok;
                        else                   raise   = ERR_BAD_SYMBOL;
                    end
                end
            endcase
        end

        // Build the command
        push      = 1'b0;
        cmd       = '0;
        cmd.last  = last_v;
        if (raise != ERR_NONE) begin
            push      = 1'b1;
            cmd.err   = raise;
            cmd.eline = 16'(r_line);
        end else if (flush) begin
            push = 1'b1;
            case (r_mode)
                M_IDENT: begin
                    if (kw_hit) begin
                        cmd.tok = kw_tok;
                    end else begin
                        cmd.tok      = TOK_IDENT;
                        cmd.is_ident = 1'b1;
                    end
                end
                M_NUM: begin
                    cmd.tok = TOK_NUMBER;
                    cmd.num = 17'(r_acc);
                end
                M_LT:    cmd.tok = TOK_LT;
                M_GT:    cmd.tok = TOK_GT;
                default: cmd.tok = TOK_SLASH;
            endcase
        end else if (tok_now != TOK_NONE) begin
            push    = 1'b1;
            cmd.tok = tok_now;
        end else if (done_now) begin
            push      = 1'b1;
            cmd.done  = 1'b1;
            cmd.err   = r_err;
            cmd.eline = (r_err != ERR_NONE) ? 16'(r_line) : 16'd0;
        end

        adv        = i_in_valid && (!push || i_q_ready);
        o_in_ready = consume && (!push || i_q_ready);
        o_push     = i_in_valid && push && i_q_ready;
        o_cmd      = cmd;
    end

    assign o_ident = r_buf;
    assign o_len   = r_len;

    // Next state
    always_comb begin
        n_mode = r_mode;
        n_buf  = r_buf;
        n_len  = r_len;
        n_acc  = r_acc;
        n_dcnt = r_dcnt;
        n_line = r_line;
        n_err  = r_err;
        if (adv) begin
            if (eot) begin
                if (r_err == ERR_NONE && pending) begin
                    n_mode = M_IDLE;
                    n_err  = raise;
                end else begin
                    // end of text: back to reset for the next text
                    n_mode = M_IDLE;
                    n_len  = '0;
                    n_acc  = '0;
                    n_dcnt = '0;
                    n_line = '0;
                    n_err  = ERR_NONE;
                end
            end else if (r_err == ERR_NONE) begin
                if (raise != ERR_NONE) begin
                    n_err  = raise;
                    n_mode = M_IDLE;
                end else begin
                    case (r_mode)
                        M_IDENT: begin
                            if (c_alnum) begin
                                n_buf[r_len[POS_W-1:0]] = c;
                                n_len = r_len + 1'b1;
                            end else begin
                                n_mode = M_IDLE;
                            end
                        end
                        M_NUM: begin
                            if (c_digit) begin
                                n_acc  = ACC_W'(r_acc * ACC_W'(10) + ACC_W'(c[3:0]));
                                n_dcnt = r_dcnt + 1'b1;
                            end else begin
                                n_mode = M_IDLE;
                            end
                        end
                        M_LT, M_GT, M_COLON: n_mode = M_IDLE;
                        M_SLASH: n_mode = (c == "*") ? M_COMMENT : M_IDLE;
                        M_COMMENT: begin
                            if (c == "*") begin
                                n_mode = M_CSTAR;
                            end else if (c == CH_NL) begin
                                n_line = r_line + 1'b1;
                            end
                        end
                        M_CSTAR: begin
                            if (c == "/") begin
                                n_mode = M_IDLE;
                            end else if (c != "*") begin
                                n_mode = M_COMMENT;
                                if (c == CH_NL) n_line = r_line + 1'b1;
                            end
                        end
                        default: begin
                            if (c == CH_NL) begin
                                n_line = r_line + 1'b1;
                            end else if (c_alpha) begin
                                n_buf[0] = c;
                                n_len    = LEN_W'(1);
                                n_mode   = M_IDENT;
                            end else if (c_digit) begin
                                n_acc  = ACC_W'(c[3:0]);
                                n_dcnt = DCNT_W'(1);
                                n_mode = M_NUM;
                            end else if (c == "<") begin
                                n_mode = M_LT;
                            end else if (c == ">") begin
                                n_mode = M_GT;
                            end else if (c == ":") begin
                                n_mode = M_COLON;
                            end else if (c == "/") begin
                                n_mode = M_SLASH;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_len  <= '0;
            r_acc  <= '0;
            r_dcnt <= '0;
            r_line <= '0;
            r_err  <= ERR_NONE;
        end else begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_acc  <= n_acc;
            r_dcnt <= n_dcnt;
            r_line <= n_line;
            r_err  <= n_err;
        end
    end

    // Name buffer, no reset
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    `CHK_IMPLIES(a_err_idle, i_clk, i_rst_n, r_err != ERR_NONE, r_mode == M_IDLE, "error latched outside idle")
    `CHK_HOLDS(a_len_max, i_clk, i_rst_n, r_len <= LEN_W'(IDENT_MAX), "name length past buffer")

endmodule

FILE: rtl/core/pl0lx_queue.sv
// ---------------------------------------------------------------------------
// pl0lx_queue
// Two-entry command queue between scanner and emitter; each entry carries
// the command and a snapshot of the name buffer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pl0lx_queue import pl0lx_pkg::*; #(
    parameter int IDENT_MAX = IDENT_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_ready,
    input  t_cmd                           i_cmd,
    input  logic [IDENT_MAX-1:0][7:0]      i_ident,
    input  logic [$clog2(IDENT_MAX+1)-1:0] i_len,
    output logic                           o_valid,
    input  logic                           i_pop,
    output t_cmd                           o_cmd,
    output logic [IDENT_MAX-1:0][7:0]      o_ident,
    output logic [$clog2(IDENT_MAX+1)-1:0] o_len
);

    localparam int LEN_W = $clog2(IDENT_MAX + 1);

    t_cmd                      r_cmd   [2];
    logic [IDENT_MAX-1:0][7:0] r_ident [2];
    logic [LEN_W-1:0]          r_lens  [2];
    logic                      r_wr, r_rd;
    logic [1:0]                r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_cmd[r_rd];
    assign o_ident = r_ident[r_rd];
    assign o_len   = r_lens[r_rd];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            if (i_push && !i_pop)      r_count <= r_count + 2'd1;
            else if (i_pop && !i_push) r_count <= r_count - 2'd1;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_wr]   <= i_cmd;
            r_ident[r_wr] <= i_ident;
            r_lens[r_wr]  <= i_len;
        end
    end

    `CHK_HOLDS(a_q_level, i_clk, i_rst_n, r_count <= 2'd2, "queue level past depth")

endmodule

FILE: rtl/core/pl0lx_back.sv
// ---------------------------------------------------------------------------
// pl0lx_back
// Emitter: turns queued commands into result items. A plain identifier
// expands into one result per character. Results past the per-item limit
// are dropped, and the last kept one is flagged as last.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pl0lx_back import pl0lx_pkg::*; #(
    parameter int IDENT_MAX = IDENT_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  t_cmd                           i_q_cmd,
    input  logic [IDENT_MAX-1:0][7:0]      i_q_ident,
    input  logic [$clog2(IDENT_MAX+1)-1:0] i_q_len,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output t_out                           o_out
);

    localparam int LEN_W = $clog2(IDENT_MAX + 1);
    localparam int POS_W = (IDENT_MAX > 1) ? $clog2(IDENT_MAX) : 1;

    logic [POS_W-1:0] r_pos;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ov;
    t_out             r_out;

    logic head_end, grp_end, step, emit;
    t_out res;

    // Current result from the queue head
    always_comb begin
        head_end = !i_q_cmd.is_ident || (LEN_W'(r_pos) == i_q_len - 1'b1);
        grp_end  = i_q_cmd.last && head_end;
        step     = i_q_valid && (!r_ov || i_out_ready);
        emit     = step && (r_cnt < CNT_W'(MAX_RESULTS));
        o_q_pop  = step && head_end;

        res              = '0;
        res.token_id     = i_q_cmd.tok;
        res.number_value = i_q_cmd.num;
        res.error_code   = i_q_cmd.err;
        res.error_line   = i_q_cmd.eline;
        res.done_res     = i_q_cmd.done;
        res.last         = grp_end || (r_cnt == CNT_W'(MAX_RESULTS - 1));
        if (i_q_cmd.is_ident) begin
            res.ident_char = i_q_ident[r_pos];
            res.char_pos   = 4'(r_pos);
        end
    end

    // Character position and per-item result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (step) begin
                r_pos <= head_end ? '0 : r_pos + 1'b1;
                if (grp_end) begin
                    r_cnt <= '0;
                end else if (r_cnt != CNT_W'(MAX_RESULTS)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (emit) r_out <= res;
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    `CHK_HOLDS(a_cnt_max, i_clk, i_rst_n, r_cnt <= CNT_W'(MAX_RESULTS), "result count past limit")
    `CHK_IMPLIES(a_pos_in_name, i_clk, i_rst_n, i_q_valid && i_q_cmd.is_ident, LEN_W'(r_pos) < i_q_len, "char position past name")

endmodule

FILE: rtl/core/pl0_lexer_unit.sv
// ---------------------------------------------------------------------------
// pl0_lexer_unit
// PL/0 lexical analyzer: source bytes in, tokens and errors out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in): one source byte per item,
//   or an end-of-text marker that flushes the pending token and yields the
//   done result carrying any latched error.
//   Output channel (o_out_valid / i_out_ready / o_out): result items; the last
//   result caused by an input item has o_out.last set.
//   Throughput: one byte per cycle while the queue has room. A byte that closes
//   a pending name, number or lookahead operator, and end of text after a
//   pending token, are held back while the scanner sends the pending token
//   first. A name expands into one result per character, one per cycle out of
//   the emitter while the receiver keeps up. Result path: with the queue empty
//   and the output register free, the first result of an item goes through a
//   queue entry, then the output register. A pending token sent ahead of the
//   byte that closes it is written into the queue before that byte is accepted.
//   A two-entry command queue sits between scanner and emitter; when the
//   receiver stalls the queue fills and o_in_ready drops.
//   Reset (synchronous, active low): scanner idle, line count and error
//   cleared, queue and output register empty. End of text restores the same
//   scanner state for the next text.
// ---------------------------------------------------------------------------
module pl0_lexer_unit import pl0lx_pkg::*; #(
    parameter int IDENT_MAX      = IDENT_MAX_DEF,
    parameter int NUM_DIGITS_MAX = NUM_DIGITS_MAX_DEF,
    parameter int LINE_BITS      = LINE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int LEN_W = $clog2(IDENT_MAX + 1);

    logic                      f_push, q_ready, q_valid, q_pop;
    t_cmd                      f_cmd, q_cmd;
    logic [IDENT_MAX-1:0][7:0] f_ident, q_ident;
    logic [LEN_W-1:0]          f_len, q_len;

    pl0lx_front #(
        .IDENT_MAX      (IDENT_MAX),
        .NUM_DIGITS_MAX (NUM_DIGITS_MAX),
        .LINE_BITS      (LINE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_push     (f_push),
        .i_q_ready  (q_ready),
        .o_cmd      (f_cmd),
        .o_ident    (f_ident),
        .o_len      (f_len)
    );

    pl0lx_queue #(
        .IDENT_MAX (IDENT_MAX)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .o_ready (q_ready),
        .i_cmd   (f_cmd),
        .i_ident (f_ident),
        .i_len   (f_len),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_ident (q_ident),
        .o_len   (q_len)
    );

    pl0lx_back #(
        .IDENT_MAX (IDENT_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .i_q_ident   (q_ident),
        .i_q_len     (q_len),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
